@@ rtl/drs_pkg.sv @@
// shared constants, command and status types for the decimal radix sorter
package drs_pkg;

	localparam int VALUE_W      = 31;
	localparam int PASS_W       = 4;
	localparam int DIGIT_W      = 4;
	localparam int RADIX        = 10;
	localparam int MAX_PASSES   = 10;
	localparam int MAX_ITEMS_DEF = 64;
	localparam int TDATA_W      = 32;

	// divide by ten: q * RECIP >> RECIP_SHIFT is exact for any 32-bit q
	localparam logic [31:0] RECIP = 32'hCCCC_CCCD;
	localparam int RECIP_SHIFT    = 35;
	localparam int PROD_W         = VALUE_W + 32;
	localparam int QUOT_W         = PROD_W - RECIP_SHIFT;

	// controller to datapath
	typedef struct packed {
		logic load_wr;
		logic cnt_clr;
		logic scan_init;
		logic counts_clr;
		logic rd_issue;
		logic pipe_en;
		logic mode_dist;
		logic prefix_step;
		logic src_bank;
		logic out_load;
	} drs_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic full;
		logic scan_done;
		logic out_taken;
		logic out_last;
	} drs_stat_t;

endpackage

@@ rtl/decimal_radix_sort.sv @@
// top level of the decimal radix sorter
//
// Collects up to MAX_ITEMS non-negative 31-bit words until one marked tlast, then
// sorts them ascending with a stable base-10 LSD radix sort over digit_passes digit
// positions (a count above 10 acts as 10, zero gives load order) and streams them
// out with the final word marked tlast; words beyond capacity are dropped, but
// their tlast still closes the set. Loading takes a word whenever tvalid is high.
// Each digit pass makes one read scan to count bucket sizes, one prefix step per
// bucket to turn the counts into start offsets, and one read scan that writes each
// word to its bucket slot in the other ping-pong bank, both scans paced by the
// single read port of the source bank and a three-stage digit pipeline. Emission
// reads one word at a time into the output register. No input word is taken from
// the word carrying tlast until the last sorted word has been delivered.
module decimal_radix_sort #(
	parameter int MAX_ITEMS = drs_pkg::MAX_ITEMS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [drs_pkg::PASS_W-1:0]  cfg_wdata,      // digit_passes
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [drs_pkg::TDATA_W-1:0] s_axis_tdata,   // [30:0] value, [31] zero
	input  logic                        s_axis_tlast,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [drs_pkg::TDATA_W-1:0] m_axis_tdata,   // [30:0] sorted_value, [31] zero
	output logic                        m_axis_tlast
);

	import drs_pkg::*;

	drs_cmd_t           cmd;
	drs_stat_t          stat;
	logic [VALUE_W-1:0] out_value;

	drs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	drs_datapath #(
		.MAX_ITEMS(MAX_ITEMS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_value (s_axis_tdata[VALUE_W-1:0]),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_value(out_value),
		.out_last (m_axis_tlast)
	);

	assign m_axis_tdata = TDATA_W'(out_value);

endmodule

@@ rtl/drs_ram.sv @@
// generic simple dual-port ram with registered read
module drs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/drs_datapath.sv @@
// datapath: two ping-pong banks, digit pipeline, bucket counters, output register
module drs_datapath #(
	parameter int MAX_ITEMS = drs_pkg::MAX_ITEMS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  drs_pkg::drs_cmd_t          cmd,
	output drs_pkg::drs_stat_t         stat,
	input  logic [drs_pkg::VALUE_W-1:0] in_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [drs_pkg::VALUE_W-1:0] out_value,
	output logic                       out_last
);

	import drs_pkg::*;

	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int RW = 2 * VALUE_W;

	logic [CW-1:0] item_cnt_q;
	logic [CW-1:0] rd_idx_q;
	logic          issue_done;
	logic          rd_go;

	logic          valid_s1, valid_s2, valid_s3;
	logic          rd_bank_s1;
	logic [RW-1:0] rdata0, rdata1, rdata_s1;
	logic [VALUE_W-1:0] v_s2, q_s2, v_s3;
	logic [PROD_W-1:0]  prod_s2;
	logic [QUOT_W-1:0]  qd, qd_s3;
	logic [VALUE_W-1:0] ten_qd, rem;
	logic [DIGIT_W-1:0] digit_s3;

	logic [CW-1:0] cnt_q [RADIX];
	logic [CW-1:0] acc_q;
	logic [CW-1:0] cnt_sel;

	logic          we0, we1;
	logic [AW-1:0] waddr0, waddr1;
	logic [RW-1:0] wdata0, wdata1;
	logic          dist_wr;

	logic          out_valid_q, out_last_q;
	logic [VALUE_W-1:0] out_value_q;

	assign issue_done = (rd_idx_q == item_cnt_q);
	assign rd_go      = cmd.rd_issue & ~issue_done;

	assign stat.full      = (item_cnt_q == CW'(MAX_ITEMS));
	assign stat.scan_done = issue_done & ~(valid_s1 | valid_s2 | valid_s3);
	assign stat.out_taken = out_valid_q & out_ready;
	assign stat.out_last  = out_last_q;

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_cnt_q  <= '0;
			rd_idx_q    <= '0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
			for (int i = 0; i < RADIX; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			if (cmd.cnt_clr) begin
				item_cnt_q <= '0;
			end else if (cmd.load_wr) begin
				item_cnt_q <= item_cnt_q + CW'(1);
			end

			if (cmd.scan_init || cmd.cnt_clr) begin
				rd_idx_q <= '0;
			end else if (rd_go) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end

			valid_s1 <= rd_go & cmd.pipe_en;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;

			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (stat.out_taken) begin
				out_valid_q <= 1'b0;
			end

			// bucket counters: count, then rotate into start offsets, then bump on write
			if (cmd.counts_clr) begin
				acc_q <= '0;
				for (int i = 0; i < RADIX; i++) begin
					cnt_q[i] <= '0;
				end
			end else if (cmd.prefix_step) begin
				acc_q <= acc_q + cnt_q[0];
				for (int i = 0; i < RADIX - 1; i++) begin
					cnt_q[i] <= cnt_q[i+1];
				end
				cnt_q[RADIX-1] <= acc_q;
			end else if (valid_s3) begin
				for (int i = 0; i < RADIX; i++) begin
					if (digit_s3 == DIGIT_W'(i)) begin
						cnt_q[i] <= cnt_q[i] + CW'(1);
					end
				end
			end
		end
	end

	// payload pipeline: s1 ram word, s2 product by reciprocal, s3 digit and quotient
	assign rdata_s1 = rd_bank_s1 ? rdata1 : rdata0;
	assign qd       = prod_s2[PROD_W-1:RECIP_SHIFT];
	assign ten_qd   = VALUE_W'({qd, 3'b000}) + VALUE_W'({qd, 1'b0});
	assign rem      = q_s2 - ten_qd;

	always_ff @(posedge clk) begin
		if (rd_go) begin
			rd_bank_s1 <= cmd.src_bank;
		end
		v_s2     <= rdata_s1[RW-1:VALUE_W];
		q_s2     <= rdata_s1[VALUE_W-1:0];
		prod_s2  <= PROD_W'(rdata_s1[VALUE_W-1:0]) * PROD_W'(RECIP);
		v_s3     <= v_s2;
		qd_s3    <= qd;
		digit_s3 <= rem[DIGIT_W-1:0];
		if (cmd.out_load) begin
			out_value_q <= rdata_s1[RW-1:VALUE_W];
			out_last_q  <= issue_done;
		end
	end

	always_comb begin
		cnt_sel = '0;
		for (int i = 0; i < RADIX; i++) begin
			if (digit_s3 == DIGIT_W'(i)) begin
				cnt_sel = cnt_q[i];
			end
		end
	end

	// bank 0 takes loads, the destination bank takes the distributed words
	assign dist_wr = valid_s3 & cmd.mode_dist;
	assign we0     = cmd.load_wr | (dist_wr & cmd.src_bank);
	assign we1     = dist_wr & ~cmd.src_bank;
	assign waddr0  = cmd.load_wr ? item_cnt_q[AW-1:0] : cnt_sel[AW-1:0];
	assign waddr1  = cnt_sel[AW-1:0];
	assign wdata1  = {v_s3, VALUE_W'(qd_s3)};
	assign wdata0  = cmd.load_wr ? {in_value, in_value} : wdata1;

	drs_ram #(
		.WIDTH(RW),
		.DEPTH(MAX_ITEMS)
	) u_bank0 (
		.clk  (clk),
		.we   (we0),
		.waddr(waddr0),
		.wdata(wdata0),
		.re   (rd_go),
		.raddr(rd_idx_q[AW-1:0]),
		.rdata(rdata0)
	);

	drs_ram #(
		.WIDTH(RW),
		.DEPTH(MAX_ITEMS)
	) u_bank1 (
		.clk  (clk),
		.we   (we1),
		.waddr(waddr1),
		.wdata(wdata1),
		.re   (rd_go),
		.raddr(rd_idx_q[AW-1:0]),
		.rdata(rdata1)
	);

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		item_cnt_q <= CW'(MAX_ITEMS))
		else $error("item count above capacity");

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_idx_q <= item_cnt_q)
		else $error("read index past item count");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> digit_s3 < DIGIT_W'(RADIX))
		else $error("decimal digit out of range");

	a_dist_addr: assert property (@(posedge clk) disable iff (!arst_n)
		dist_wr |-> cnt_sel < item_cnt_q)
		else $error("bucket write address past item count");
`endif

endmodule

@@ rtl/drs_ctrl.sv @@
// controller: load, count, prefix, distribute and emit sequencing
module drs_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [drs_pkg::PASS_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	input  logic                       in_last,
	output logic                       in_ready,
	output drs_pkg::drs_cmd_t          cmd,
	input  drs_pkg::drs_stat_t         stat
);

	import drs_pkg::*;

	typedef enum logic [6:0] {
		ST_LOAD     = 7'b0000001,
		ST_COUNT    = 7'b0000010,
		ST_PREFIX   = 7'b0000100,
		ST_DIST     = 7'b0001000,
		ST_EMIT_RD  = 7'b0010000,
		ST_EMIT_LD  = 7'b0100000,
		ST_EMIT_OUT = 7'b1000000
	} state_t;

	state_t              state_q, state_d;
	logic [PASS_W-1:0]   digit_passes_q;
	logic [PASS_W-1:0]   passes_eff;
	logic [PASS_W-1:0]   pass_q;
	logic [DIGIT_W-1:0]  step_q;

	// counts above ten act as ten
	assign passes_eff = (digit_passes_q > PASS_W'(MAX_PASSES)) ? PASS_W'(MAX_PASSES)
		: digit_passes_q;

	always_comb begin
		cmd          = '0;
		cmd.src_bank = pass_q[0];
		in_ready     = 1'b0;
		state_d      = state_q;
		unique case (state_q)
			ST_LOAD: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_wr = ~stat.full;
					if (in_last) begin
						cmd.scan_init = 1'b1;
						if (passes_eff == '0) begin
							state_d = ST_EMIT_RD;
						end else begin
							cmd.counts_clr = 1'b1;
							state_d        = ST_COUNT;
						end
					end
				end
			end
			ST_COUNT: begin
				cmd.rd_issue = 1'b1;
				cmd.pipe_en  = 1'b1;
				if (stat.scan_done) begin
					state_d = ST_PREFIX;
				end
			end
			ST_PREFIX: begin
				cmd.prefix_step = 1'b1;
				if (step_q == DIGIT_W'(RADIX - 1)) begin
					cmd.scan_init = 1'b1;
					state_d       = ST_DIST;
				end
			end
			ST_DIST: begin
				cmd.rd_issue  = 1'b1;
				cmd.pipe_en   = 1'b1;
				cmd.mode_dist = 1'b1;
				if (stat.scan_done) begin
					cmd.scan_init = 1'b1;
					if (pass_q + PASS_W'(1) == passes_eff) begin
						state_d = ST_EMIT_RD;
					end else begin
						cmd.counts_clr = 1'b1;
						state_d        = ST_COUNT;
					end
				end
			end
			ST_EMIT_RD: begin
				cmd.rd_issue = 1'b1;
				state_d      = ST_EMIT_LD;
			end
			ST_EMIT_LD: begin
				cmd.out_load = 1'b1;
				state_d      = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				if (stat.out_taken) begin
					if (stat.out_last) begin
						cmd.cnt_clr = 1'b1;
						state_d     = ST_LOAD;
					end else begin
						state_d = ST_EMIT_RD;
					end
				end
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_LOAD;
			digit_passes_q <= PASS_W'(MAX_PASSES);
			pass_q         <= '0;
			step_q         <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				digit_passes_q <= cfg_wdata;
			end
			if (state_q == ST_LOAD) begin
				pass_q <= '0;
			end else if (state_q == ST_DIST && stat.scan_done) begin
				pass_q <= pass_q + PASS_W'(1);
			end
			if (state_q == ST_PREFIX) begin
				step_q <= step_q + DIGIT_W'(1);
			end else begin
				step_q <= '0;
			end
		end
	end

endmodule

@@ dv/decimal_radix_sort_checker.sv @@
// checker for the decimal radix sorter: tracks loaded sets, predicts sorted output, compares
`timescale 1ns / 1ps

module decimal_radix_sort_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [drs_pkg::PASS_W-1:0]  cfg_wdata,
	input  logic                        s_axis_tvalid,
	input  logic                        s_axis_tready,
	input  logic [drs_pkg::TDATA_W-1:0] s_axis_tdata,   // [30:0] value, [31] zero
	input  logic                        s_axis_tlast,
	input  logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	input  logic [drs_pkg::TDATA_W-1:0] m_axis_tdata,   // [30:0] sorted_value, [31] zero
	input  logic                        m_axis_tlast,
	output int                          mismatches,
	output int                          words_owed
);

	import drs_pkg::*;

	typedef struct {
		logic [VALUE_W-1:0] value;
		logic               last;
	} sorted_word_t;

	logic [PASS_W-1:0]  digit_passes;
	logic [VALUE_W-1:0] loaded_words[$];
	sorted_word_t       sorted_expect[$];
	int                 mismatch_count = 0;

	task automatic report_mismatch(input string msg);
		$display("[%0t] sorted output mismatch: %s", $time, msg);
		mismatch_count++;
	endtask

	// a stable sort keyed on the low decimal digits gives the same order as the digit passes
	task automatic queue_sorted_set();
		longint unsigned    modulus;
		logic [VALUE_W-1:0] held;
		sorted_word_t       entry;
		int                 used;
		int                 i;
		int                 j;
		used = (digit_passes > MAX_PASSES) ? MAX_PASSES : int'(digit_passes);
		modulus = 1;
		repeat (used) modulus = modulus * RADIX;
		for (i = 1; i < loaded_words.size(); i++) begin
			held = loaded_words[i];
			j = i - 1;
			while (j >= 0 && (loaded_words[j] % modulus) > (held % modulus)) begin
				loaded_words[j + 1] = loaded_words[j];
				j--;
			end
			loaded_words[j + 1] = held;
		end
		for (i = 0; i < loaded_words.size(); i++) begin
			entry.value = loaded_words[i];
			entry.last  = (i == loaded_words.size() - 1);
			sorted_expect.push_back(entry);
		end
		loaded_words.delete();
	endtask

	always @(posedge clk or negedge arst_n) begin
		sorted_word_t want;
		if (!arst_n) begin
			digit_passes = PASS_W'(MAX_PASSES);
			loaded_words.delete();
			sorted_expect.delete();
		end else begin
			if (cfg_we) begin
				digit_passes = cfg_wdata;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				// words past capacity are dropped, their tlast still closes the set
				if (loaded_words.size() < MAX_ITEMS_DEF) begin
					loaded_words.push_back(s_axis_tdata[VALUE_W-1:0]);
				end
				if (s_axis_tlast) begin
					queue_sorted_set();
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (sorted_expect.size() == 0) begin
					report_mismatch($sformatf("unexpected word %h last %b",
						m_axis_tdata, m_axis_tlast));
				end else begin
					want = sorted_expect.pop_front();
					if (m_axis_tdata[VALUE_W-1:0] !== want.value || m_axis_tlast !== want.last ||
							m_axis_tdata[TDATA_W-1:VALUE_W] !== '0) begin
						report_mismatch($sformatf("got value %0d last %b pad %b, want %0d last %b",
							m_axis_tdata[VALUE_W-1:0], m_axis_tlast,
							m_axis_tdata[TDATA_W-1:VALUE_W], want.value, want.last));
					end
				end
			end
		end
		mismatches <= mismatch_count;
		words_owed <= sorted_expect.size();
	end

endmodule

@@ dv/decimal_radix_sort_tb.sv @@
// testbench top for the decimal radix sorter: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module decimal_radix_sort_tb;
	import drs_pkg::*;

	localparam int SETTLE_CYCLES = 24;
	localparam int RANDOM_WORDS  = 215;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [PASS_W-1:0]  cfg_wdata;
	logic               s_axis_tvalid;
	logic               s_axis_tready;
	logic [TDATA_W-1:0] s_axis_tdata;   // [30:0] value, [31] zero
	logic               s_axis_tlast;
	logic               m_axis_tvalid;
	logic               m_axis_tready;
	logic [TDATA_W-1:0] m_axis_tdata;   // [30:0] sorted_value, [31] zero
	logic               m_axis_tlast;

	int   mismatches;
	int   words_owed;
	int   random_words = 0;
	logic send_steady  = 1'b0;
	logic take_steady  = 1'b0;

	decimal_radix_sort i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	decimal_radix_sort_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.mismatches    (mismatches),
		.words_owed    (words_owed)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic send_word(input logic [VALUE_W-1:0] v, input logic last);
		int gap;
		if ($urandom_range(0, 15) == 0) begin
			send_steady = !send_steady;
		end
		gap = send_steady ? 0 : $urandom_range(0, 6);
		repeat (gap) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, v};
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// wait until every sorted word is back and the sorter has settled
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (words_owed != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_digit_passes(input logic [PASS_W-1:0] passes);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= passes;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		logic [31:0]        r;
		logic [VALUE_W-1:0] v;
		r = $urandom;
		case ($urandom_range(0, 3))
			0: begin
				v = r[VALUE_W-1:0];
			end
			1: begin
				v = VALUE_W'($urandom_range(0, 999));
			end
			2: begin
				// many equal low digits, so partial passes show the stable order
				v = VALUE_W'($urandom_range(0, 20) * 1000 + $urandom_range(0, 3));
			end
			default: begin
				case (r[1:0])
					2'd0: v = '0;
					2'd1: v = '1;
					2'd2: v = 31'd1000000000;
					default: v = 31'h7FFF_FFF8 + VALUE_W'($urandom_range(0, 7));
				endcase
			end
		endcase
		return v;
	endfunction

	task automatic send_set(input int count);
		for (int k = 0; k < count; k++) begin
			send_word(pick_value(), k == count - 1);
			random_words++;
		end
	endtask

	initial begin
		cfg_we        = 1'b0;
		cfg_wdata     = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		arst_n        = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setting of ten passes: single word set, extremes, alternating bits
		send_word(31'h7FFF_FFFF, 1'b1);
		send_word(31'd0, 1'b0);
		send_word(31'h7FFF_FFFF, 1'b0);
		send_word(31'd1, 1'b0);
		send_word(31'd1000000000, 1'b0);
		send_word(31'd999999999, 1'b0);
		send_word(31'd10, 1'b0);
		send_word(31'd1, 1'b1);
		send_word(31'h5555_5555, 1'b0);
		send_word(31'h2AAA_AAAA, 1'b1);

		// units digit only, ties keep load order
		set_digit_passes(PASS_W'(1));
		send_word(31'd21, 1'b0);
		send_word(31'd11, 1'b0);
		send_word(31'd35, 1'b0);
		send_word(31'd1, 1'b0);
		send_word(31'd40, 1'b1);

		// no passes at all
		set_digit_passes(PASS_W'(0));
		send_word(31'd3, 1'b0);
		send_word(31'd1, 1'b0);
		send_word(31'd2, 1'b1);

		// counts above ten behave as ten
		set_digit_passes(PASS_W'(15));
		send_word(31'd2000000000, 1'b0);
		send_word(31'd123, 1'b0);
		send_word(31'd2000000001, 1'b1);

		// overfull set first, the tail words are dropped
		send_set(MAX_ITEMS_DEF + 6);
		while (random_words < RANDOM_WORDS) begin
			set_digit_passes(PASS_W'($urandom_range(0, 15)));
			repeat ($urandom_range(2, 5)) begin
				if ($urandom_range(0, 15) == 0) begin
					send_set($urandom_range(MAX_ITEMS_DEF - 4, MAX_ITEMS_DEF + 6));
				end else begin
					send_set($urandom_range(1, 12));
				end
			end
		end

		drain_results();
		if (mismatches == 0) begin
			$display("decimal_radix_sort test passed");
		end else begin
			$display("decimal_radix_sort test failed");
		end
		$finish;
	end

	initial begin
		int hold;
		m_axis_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0) begin
				take_steady = !take_steady;
			end
			hold = take_steady ? 0 : $urandom_range(0, 6);
			repeat (hold) begin
				m_axis_tready <= 1'b0;
				@(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	initial begin
		#30_000_000;
		$display("decimal_radix_sort test failed");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/drs_pkg.sv
rtl/drs_ram.sv
rtl/drs_datapath.sv
rtl/drs_ctrl.sv
rtl/decimal_radix_sort.sv
dv/decimal_radix_sort_checker.sv
dv/decimal_radix_sort_tb.sv
